@@ rtl/core/hlxfd_pkg.sv @@
`timescale 1ns / 1ps

package hlxfd_pkg;

    // Result kinds, carried on tuser
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_BAD       = 2'd2;
    localparam logic [1:0] KIND_FRAME_ERR = 2'd3;

    // Frame marker characters
    localparam logic [7:0] CHR_U   = 8'h55;
    localparam logic [7:0] CHR_N   = 8'h4E;
    localparam logic [7:0] CHR_E   = 8'h45;
    localparam logic [7:0] CHR_R   = 8'h52;
    localparam logic [7:0] CHR_SEP = 8'h3A;

    // Parser phase codes
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_HDR_N = 3'd1;
    localparam logic [2:0] PH_HDR_E = 3'd2;
    localparam logic [2:0] PH_HDR_R = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_SEP   = 3'd5;
    localparam logic [2:0] PH_BODY  = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

endpackage

@@ rtl/core/hlxfd_parse.sv @@
`timescale 1ns / 1ps

module hlxfd_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output hlxfd_pkg::result_t res
);
    import hlxfd_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] chk_reg, chk_next;
    logic       emit;
    logic [1:0] kind;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        chk_next   = chk_reg;
        emit       = 1'b0;
        kind       = KIND_PAYLOAD;
        unique case (phase_reg)
            PH_HDR_N, PH_HDR_E, PH_HDR_R, PH_SEP:
            begin
                if ((phase_reg == PH_HDR_N && rx_byte != CHR_N) ||
                    (phase_reg == PH_HDR_E && rx_byte != CHR_E) ||
                    (phase_reg == PH_HDR_R && rx_byte != CHR_R) ||
                    (phase_reg == PH_SEP   && rx_byte != CHR_SEP))
                begin
                    // wrong marker: error and back to hunting, byte consumed
                    emit       = 1'b1;
                    kind       = KIND_FRAME_ERR;
                    phase_next = PH_HUNT;
                    left_next  = '0;
                    chk_next   = '0;
                end
                else
                begin
                    chk_next   = chk_reg ^ rx_byte;
                    phase_next = (phase_reg == PH_SEP) ? PH_BODY : phase_reg + 3'd1;
                end
            end
            PH_LEN:
            begin
                chk_next   = chk_reg ^ rx_byte;
                // zero length acts as one: check byte follows directly
                left_next  = (rx_byte == 8'd0) ? 8'd1 : rx_byte;
                phase_next = PH_SEP;
            end
            PH_BODY:
            begin
                emit = 1'b1;
                if (left_reg > 8'd1)
                begin
                    kind      = KIND_PAYLOAD;
                    chk_next  = chk_reg ^ rx_byte;
                    left_next = left_reg - 8'd1;
                end
                else
                begin
                    kind       = (chk_reg == rx_byte) ? KIND_GOOD : KIND_BAD;
                    phase_next = PH_HUNT;
                    left_next  = '0;
                    chk_next   = '0;
                end
            end
            default:
            begin
                // hunting, and the unused code
                if (rx_byte == CHR_U)
                begin
                    chk_next   = rx_byte;
                    left_next  = '0;
                    phase_next = PH_HDR_N;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            chk_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            chk_reg   <= chk_next;
        end
    end

    assign res_valid = accept & emit;
    assign res.kind  = kind;
    assign res.data  = rx_byte;

endmodule

@@ rtl/core/hlxfd_skid.sv @@
`timescale 1ns / 1ps

module hlxfd_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hlxfd_pkg::result_t push_res,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_ready,
    output hlxfd_pkg::result_t out_res
);
    import hlxfd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    pop;

    assign pop = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_res_reg <= push_res;
            end
            else
            begin
                out_res_reg <= push_res;
            end
        end
    end

    assign ready     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ rtl/core/header_length_xor_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Signals                  | Content
// ---------+-----+--------------------------+-------------------------------
// s (in)   | in  | s_tvalid/s_tready/s_tdata | tdata[7:0] rx_byte
// m (out)  | out | m_tvalid/m_tready/m_tdata | tdata[7:0] out_byte,
//          |     | m_tuser                   | tuser[1:0] out_kind
//
// One input beat per cycle while s_tready is high. The parser state updates in
// the accept cycle and each result lands in a two-entry output register, so
// s_tready is a register bit and drops only while both entries hold results
// (m_tready held low).
// Reset (rst_n low, async) returns the parser to hunting and empties the
// output register.

module header_length_xor_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser    // [1:0] out_kind
);
    import hlxfd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign accept = s_tvalid & s_tready;

    // header/length/check sequencing
    hlxfd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register with skid entry
    hlxfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.kind;

endmodule

@@ rtl/core/hlxfd_checker.sv @@
`timescale 1ns / 1ps

module hlxfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // input backpressure only with a result pending
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a new result comes only from an accepted input beat
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an input beat");

endmodule

bind header_length_xor_frame_deframer_core hlxfd_checker u_hlxfd_checker (.*);

@@ tb/sv/header_length_xor_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module header_length_xor_frame_deframer_core_tb;

    import hlxfd_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BEATS = 180;
    localparam int DRAIN_CYCLES = 20;

    // How a generated frame is spoiled, if at all
    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_CHECK,
        FRAME_BAD_MARKER
    } frame_flaw_e;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic [1:0] m_tuser;   // [1:0] out_kind

    header_length_xor_frame_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Mirror of the parser state, advanced on every accepted input beat
    logic [2:0] trk_phase;
    logic [7:0] trk_left;
    logic [7:0] trk_check;

    // Results the deframer still owes, oldest first
    result_t    owed_results[$];

    // Bytes of the frame being built before it goes out
    logic [7:0] tx_bytes[$];

    // Idling controls shared with the receiver process
    bit         tx_gaps_on;
    bit         rx_gaps_on;
    int         rx_hold_request;

    int         cycle_count;
    int         errors;
    int         beats_offered;
    int         beats_in;
    int         results_seen;
    int         payload_seen;
    int         good_seen;
    int         bad_seen;
    int         frame_err_seen;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void owe_result(input logic [1:0] kind, input logic [7:0] data);
        result_t r;
        r.kind = kind;
        r.data = data;
        owed_results.push_back(r);
    endfunction

    function automatic void clear_tracker();
        trk_phase = PH_HUNT;
        trk_left  = 8'd0;
        trk_check = 8'd0;
    endfunction

    // Header letters and separator: match advances, anything else is a
    // framing error that eats the byte and drops back to hunting
    function automatic void track_marker(input logic [7:0] b, input logic [7:0] want,
                                         input logic [2:0] nxt);
        if (b == want)
        begin
            trk_check ^= b;
            trk_phase  = nxt;
        end
        else
        begin
            owe_result(KIND_FRAME_ERR, b);
            clear_tracker();
        end
    endfunction

    // Predict what one accepted byte does to the parser
    function automatic void track_rx_byte(input logic [7:0] b);
        case (trk_phase)
            PH_HDR_N: track_marker(b, CHR_N, PH_HDR_E);
            PH_HDR_E: track_marker(b, CHR_E, PH_HDR_R);
            PH_HDR_R: track_marker(b, CHR_R, PH_LEN);
            PH_SEP:   track_marker(b, CHR_SEP, PH_BODY);
            PH_LEN:
            begin
                // zero length still enters the check but counts as one
                trk_check ^= b;
                trk_left   = (b == 8'd0) ? 8'd1 : b;
                trk_phase  = PH_SEP;
            end
            PH_BODY:
            begin
                if (trk_left > 8'd1)
                begin
                    trk_check ^= b;
                    trk_left   = trk_left - 8'd1;
                    owe_result(KIND_PAYLOAD, b);
                end
                else
                begin
                    owe_result((trk_check == b) ? KIND_GOOD : KIND_BAD, b);
                    clear_tracker();
                end
            end
            default:
            begin
                // hunting: only 'U' starts a header, the rest is dropped
                if (b == CHR_U)
                begin
                    trk_check = b;
                    trk_left  = 8'd0;
                    trk_phase = PH_HDR_N;
                end
                else
                begin
                    trk_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    // Clock and run-length watchdog
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, owed_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Input monitor: every accepted beat feeds the tracker
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            track_rx_byte(s_tdata);
            beats_in <= beats_in + 1;
        end
    end

    // Output checker: each accepted result against the oldest owed one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d byte %02h",
                         $time, m_tuser, m_tdata);
                errors = errors + 1;
            end
            else
            begin
                want = owed_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $display("%0t: out_kind mismatch, expected %0d, actual %0d",
                             $time, want.kind, m_tuser);
                    errors = errors + 1;
                end
                if (m_tdata !== want.data)
                begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.data, m_tdata);
                    errors = errors + 1;
                end
                case (want.kind)
                    KIND_PAYLOAD: payload_seen   <= payload_seen + 1;
                    KIND_GOOD:    good_seen      <= good_seen + 1;
                    KIND_BAD:     bad_seen       <= bad_seen + 1;
                    default:      frame_err_seen <= frame_err_seen + 1;
                endcase
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request.
    // The hold is counted here so the sender keeps pushing meanwhile.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                stall           = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall = stall - 1;
            end
            else if (rx_gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                stall = pick_gap() - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte and return at the edge where it is taken.
    // tvalid stays high on return so back-to-back beats need no toggle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        beats_offered = beats_offered + 1;
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
    endtask

    task automatic release_bus();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Frame assembly: header, length, separator, then payload by the caller
    task automatic start_frame(input logic [7:0] len);
        tx_bytes.delete();
        tx_bytes.push_back(CHR_U);
        tx_bytes.push_back(CHR_N);
        tx_bytes.push_back(CHR_E);
        tx_bytes.push_back(CHR_R);
        tx_bytes.push_back(len);
        tx_bytes.push_back(CHR_SEP);
    endtask

    task automatic finish_frame(input bit corrupt_check);
        logic [7:0] x;
        x = 8'd0;
        foreach (tx_bytes[i])
            x ^= tx_bytes[i];
        if (corrupt_check)
            x ^= 8'($urandom_range(1, 255));
        tx_bytes.push_back(x);
    endtask

    // Send the assembled bytes; optionally stop before beat pause_at
    // until every owed result is back, then carry on mid-frame
    task automatic send_queued(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
            begin
                release_bus();
                wait_drained();
            end
            send_byte(tx_bytes[i]);
        end
    endtask

    task automatic send_frame(input int len, input frame_flaw_e flaw, input int pause_at);
        int cut;
        int idx;
        start_frame(8'(len));
        for (int i = 1; i < len; i++)
            tx_bytes.push_back(8'($urandom));
        finish_frame(flaw == FRAME_BAD_CHECK);
        if (flaw == FRAME_BAD_MARKER)
        begin
            // spoil one of N, E, R or ':' and stop right after it
            idx = $urandom_range(0, 3);
            cut = (idx == 3) ? 5 : idx + 1;
            tx_bytes[cut] ^= 8'($urandom_range(1, 255));
            send_queued(cut + 1, pause_at);
        end
        else
        begin
            send_queued(tx_bytes.size(), pause_at);
        end
    endtask

    // Line noise while hunting; never 'U' so the next frame stays aligned
    task automatic send_noise(input int count);
        logic [7:0] x;
        for (int i = 0; i < count; i++)
        begin
            x = 8'($urandom);
            if (x == CHR_U)
                x = ~x;
            send_byte(x);
        end
    endtask

    task automatic test_directed();
        // idle bytes while hunting, including a stray header letter
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHR_N);
        // good frame, payload at both byte extremes
        start_frame(8'd3);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        finish_frame(1'b0);
        send_queued(tx_bytes.size(), -1);
        // zero length: check byte right after the separator
        start_frame(8'd0);
        finish_frame(1'b0);
        send_queued(tx_bytes.size(), -1);
        // bad check
        start_frame(8'd2);
        tx_bytes.push_back(8'hA5);
        finish_frame(1'b1);
        send_queued(tx_bytes.size(), -1);
        // 'U' in place of 'N' is an error and is eaten, so the 'N'
        // after it is dropped while hunting
        send_byte(CHR_U);
        send_byte(CHR_U);
        send_byte(CHR_N);
        // one bad byte at each remaining marker position
        send_byte(CHR_U);
        send_byte(CHR_N);
        send_byte(8'hFF);
        send_byte(CHR_U);
        send_byte(CHR_N);
        send_byte(CHR_E);
        send_byte(8'h00);
        start_frame(8'd1);
        tx_bytes[5] = 8'h3B;
        send_queued(tx_bytes.size(), -1);
        release_bus();
    endtask

    // Largest length, plus length one good and bad
    task automatic test_long_frames();
        send_frame(255, FRAME_CLEAN, -1);
        send_frame(1, FRAME_CLEAN, -1);
        send_frame(1, FRAME_BAD_CHECK, -1);
        release_bus();
    endtask

    task automatic test_random_traffic();
        int sent;
        int seg_end;
        int r;
        int len;
        int mark;
        frame_flaw_e flaw;
        sent    = 0;
        seg_end = 0;
        while (sent < RANDOM_BEATS)
        begin
            // change idling mode every hundred or so beats; some segments
            // run flat out on both sides
            if (sent >= seg_end)
            begin
                r          = $urandom_range(0, 3);
                tx_gaps_on = r[0];
                rx_gaps_on = r[1];
                seg_end    = seg_end + 100;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_noise($urandom_range(1, 6));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    len = $urandom_range(0, 8);
                else if (r < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 120);
                r = $urandom_range(0, 99);
                if (r < 78)
                    flaw = FRAME_CLEAN;
                else if (r < 90)
                    flaw = FRAME_BAD_CHECK;
                else
                    flaw = FRAME_BAD_MARKER;
                mark = beats_offered;
                send_frame(len, flaw, -1);
                sent = sent + (beats_offered - mark);
            end
        end
        release_bus();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Receiver goes quiet while the sender streams without gaps: the
    // two-entry output register fills and s_tready must drop
    task automatic test_backpressure();
        wait_drained();
        tx_gaps_on      = 1'b0;
        rx_gaps_on      = 1'b0;
        rx_hold_request = 250;
        send_frame(60, FRAME_CLEAN, -1);
        send_frame(5, FRAME_BAD_CHECK, -1);
        release_bus();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Sender stops mid-frame until everything owed has come back
    task automatic test_sender_pause();
        send_frame(12, FRAME_CLEAN, 8);
        send_frame(4, FRAME_BAD_CHECK, 7);
        send_noise(3);
        release_bus();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'd0;
        tx_gaps_on      = 1'b1;
        rx_gaps_on      = 1'b1;
        rx_hold_request = 0;
        cycle_count     = 0;
        errors          = 0;
        beats_offered   = 0;
        beats_in        = 0;
        results_seen    = 0;
        payload_seen    = 0;
        good_seen       = 0;
        bad_seen        = 0;
        frame_err_seen  = 0;
        clear_tracker();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_frames();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();

        // drain, then give the output register time to show anything extra
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, owed_results.size());
            errors = errors + 1;
        end

        $display("Run: %0d bytes in, %0d results out (%0d payload bytes).",
                 beats_in, results_seen, payload_seen);
        $display("Frames ended good %0d, bad check %0d; framing errors %0d.",
                 good_seen, bad_seen, frame_err_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
